@@ src/lscw_pkg.sv @@
// Package for the display shadow cell writer: payload structs, command codes
// and the operation record passed from the front part to the back part.
// No dependencies.
`default_nettype none
package lscw_pkg;

	localparam int CELL_CHARS = 4;
	localparam int MAX_RESULTS = 10;
	localparam int CELL_IDX_W = 5;
	localparam int CLR_CNT_W = 4;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam logic [7:0] SPACE_CHAR = 8'h20;

	typedef enum logic [1:0] {
		CMD_TEXT  = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_LIGHT = 2'd2
	} cmd_t;

	typedef enum logic {
		KIND_CELL  = 1'b0,
		KIND_LIGHT = 1'b1
	} res_kind_t;

	typedef enum logic [1:0] {
		OP_TEXT  = 2'd0,
		OP_CLEAR = 2'd1,
		OP_LIGHT = 2'd2
	} op_kind_t;

	typedef struct packed {
		logic [1:0] command;
		logic [1:0] row;
		logic [4:0] col;
		logic [7:0] character;
		logic       first;
		logic       last;
		logic [2:0] light_id;
		logic       light_req;
	} in_item_t;

	typedef struct packed {
		logic       kind;
		logic [3:0] cell_res;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
		logic [7:0] byte3;
		logic [2:0] light_index;
		logic       light_state;
		logic       end_of_run;
	} out_item_t;

	typedef struct packed {
		op_kind_t              kind;
		logic [CELL_IDX_W-1:0] cell_num;
		logic [1:0]            off;
		logic [7:0]            ch;
		logic                  load;
		logic                  flush;
		logic [2:0]            light_id;
		logic                  light_req;
	} op_t;

	typedef logic [CELL_CHARS-1:0][7:0] cell_data_t;

endpackage
`default_nettype wire

@@ src/lcd_shadow_cell_writer.sv @@
// Top level of the display shadow cell writer: front part, operation queue
// and back part. Depends on lscw_pkg, lscw_front, lscw_queue and lscw_back.
//
//   Channel  Signals                       Payload
//   input    in_valid, in_ready, in_data   lscw_pkg::in_item_t
//   output   out_valid, out_ready, out_data lscw_pkg::out_item_t
//
// Each text or light item leaves the queue as it fires in the back part, so
// one item per cycle is sustained while the result port is not stalled.
// A clear holds the back part until it has emitted all its cells, at most ten.
// in_ready drops only when the two-entry operation queue is full.
// Reset clears both shadows at once; no clearing pass follows.
`default_nettype none
module lcd_shadow_cell_writer #(
	parameter int SCREEN_COLUMNS = 20,
	parameter int SCREEN_ROWS = 2,
	parameter int LIGHT_COUNT = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire lscw_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output lscw_pkg::out_item_t     out_data
);

	logic          push;
	lscw_pkg::op_t push_op;
	logic          q_full;
	logic          q_pop;
	logic          q_valid;
	lscw_pkg::op_t q_op;

	lscw_front #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS),
		.SCREEN_ROWS(SCREEN_ROWS),
		.LIGHT_COUNT(LIGHT_COUNT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.q_full(q_full),
		.push(push),
		.push_op(push_op)
	);

	lscw_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_op(push_op),
		.full(q_full),
		.pop(q_pop),
		.head_valid(q_valid),
		.head_op(q_op)
	);

	lscw_back #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS),
		.SCREEN_ROWS(SCREEN_ROWS),
		.LIGHT_COUNT(LIGHT_COUNT)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_op(q_op),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule
`default_nettype wire

@@ src/lscw_front.sv @@
// Front part: accepts input transactions, tracks the print cursor and
// turns each item into an operation for the queue. Depends on lscw_pkg.
`default_nettype none
module lscw_front #(
	parameter int SCREEN_COLUMNS = 20,
	parameter int SCREEN_ROWS = 2,
	parameter int LIGHT_COUNT = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire lscw_pkg::in_item_t in_data,
	input  wire logic              q_full,
	output logic                   push,
	output lscw_pkg::op_t          push_op
);

	localparam int CELLS_PER_ROW = (SCREEN_COLUMNS + lscw_pkg::CELL_CHARS - 1) /
		lscw_pkg::CELL_CHARS;

	logic [1:0] cursor_row_q;
	logic [4:0] cursor_col_q;
	logic       active_q;
	logic       pending_q;

	logic       accept;
	logic       is_text;
	logic       is_clear;
	logic       is_light;
	logic       off_screen;
	logic       act_eff;
	logic       pend_eff;
	logic [1:0] row_eff;
	logic [4:0] col_eff;
	logic [5:0] col_next;
	logic       at_edge;
	logic       flush;
	logic       text_go;
	logic       id_ok;
	logic [5:0] flat;

	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;

	always_comb begin
		is_text = in_data.command == lscw_pkg::CMD_TEXT;
		is_clear = in_data.command == lscw_pkg::CMD_CLEAR;
		is_light = in_data.command == lscw_pkg::CMD_LIGHT;
		off_screen = (3'(in_data.row) >= 3'(SCREEN_ROWS)) ||
			(6'(in_data.col) >= 6'(SCREEN_COLUMNS));
		row_eff = in_data.first ? in_data.row : cursor_row_q;
		col_eff = in_data.first ? in_data.col : cursor_col_q;
		act_eff = in_data.first ? !off_screen : active_q;
		pend_eff = in_data.first ? 1'b0 : pending_q;
		col_next = {1'b0, col_eff} + 6'd1;
		at_edge = col_next >= 6'(SCREEN_COLUMNS);
		flush = in_data.last || (col_next[1:0] == 2'd0) || at_edge;
		text_go = is_text && act_eff;
		id_ok = {29'd0, in_data.light_id} < 32'(LIGHT_COUNT);
		flat = 6'(row_eff) * 6'(CELLS_PER_ROW) + {3'd0, col_eff[4:2]};
	end

	always_comb begin
		push = accept && (text_go || is_clear || (is_light && id_ok));
		push_op.kind = is_clear ? lscw_pkg::OP_CLEAR :
			(is_light ? lscw_pkg::OP_LIGHT : lscw_pkg::OP_TEXT);
		push_op.cell_num = flat[lscw_pkg::CELL_IDX_W-1:0];
		push_op.off = col_eff[1:0];
		push_op.ch = in_data.character;
		push_op.load = !pend_eff;
		push_op.flush = flush;
		push_op.light_id = in_data.light_id;
		push_op.light_req = in_data.light_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_row_q <= '0;
			cursor_col_q <= '0;
			active_q <= 1'b0;
			pending_q <= 1'b0;
		end else if (accept) begin
			if (is_clear) begin
				active_q <= 1'b0;
				pending_q <= 1'b0;
			end else if (is_text) begin
				if (text_go) begin
					cursor_row_q <= row_eff;
					cursor_col_q <= col_next[4:0];
					pending_q <= !flush;
					active_q <= !(in_data.last || at_edge);
				end else begin
					active_q <= 1'b0;
					pending_q <= pend_eff;
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ src/lscw_queue.sv @@
// Short operation queue between the front and back parts.
// Depends on lscw_pkg.
`default_nettype none
module lscw_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire lscw_pkg::op_t push_op,
	output logic               full,
	input  wire logic          pop,
	output logic               head_valid,
	output lscw_pkg::op_t      head_op
);

	localparam int CNT_W = $clog2(lscw_pkg::QUEUE_DEPTH + 1);

	lscw_pkg::op_t                 mem_q [lscw_pkg::QUEUE_DEPTH];
	logic [lscw_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [lscw_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [CNT_W-1:0]              count_q;
	logic                          do_push;
	logic                          do_pop;

	assign full = count_q == CNT_W'(lscw_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_op = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ src/lscw_back.sv @@
// Back part: holds the screen and light shadows, merges characters into the
// open cell, and drives the registered result port. Depends on lscw_pkg.
`default_nettype none
module lscw_back #(
	parameter int SCREEN_COLUMNS = 20,
	parameter int SCREEN_ROWS = 2,
	parameter int LIGHT_COUNT = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  wire lscw_pkg::op_t q_op,
	output logic               q_pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output lscw_pkg::out_item_t out_data
);

	localparam int CELLS_PER_ROW = (SCREEN_COLUMNS + lscw_pkg::CELL_CHARS - 1) /
		lscw_pkg::CELL_CHARS;
	localparam int CELL_TOTAL = SCREEN_ROWS * CELLS_PER_ROW;
	localparam int CW = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1;
	localparam int CLEAR_COUNT = (CELL_TOTAL < lscw_pkg::MAX_RESULTS) ?
		CELL_TOTAL : lscw_pkg::MAX_RESULTS;
	localparam int LIGHT_SLOTS = (LIGHT_COUNT < 8) ? LIGHT_COUNT : 8;
	localparam int LW = (LIGHT_SLOTS > 1) ? $clog2(LIGHT_SLOTS) : 1;

	lscw_pkg::cell_data_t           shadow_q [CELL_TOTAL];
	logic [LIGHT_SLOTS-1:0]         light_q;
	lscw_pkg::cell_data_t           buf_q;
	logic [lscw_pkg::CLR_CNT_W-1:0] clr_cnt_q;
	logic                           out_valid_q;
	lscw_pkg::out_item_t            out_data_q;

	logic                 emit_ready;
	logic                 fire;
	logic [CW-1:0]        cell_idx;
	logic [LW-1:0]        light_idx;
	lscw_pkg::cell_data_t sh;
	lscw_pkg::cell_data_t merged;
	logic                 changed;
	logic                 light_chg;
	logic                 clr_last;
	logic                 res_valid;
	lscw_pkg::out_item_t  res;

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_comb begin
		emit_ready = !out_valid_q || out_ready;
		fire = q_valid && emit_ready;
		cell_idx = q_op.cell_num[CW-1:0];
		light_idx = q_op.light_id[LW-1:0];
		sh = shadow_q[cell_idx];
		merged = q_op.load ? sh : buf_q;
		merged[q_op.off] = q_op.ch;
		changed = q_op.flush && (merged != sh);
		light_chg = light_q[light_idx] != q_op.light_req;
		clr_last = clr_cnt_q == lscw_pkg::CLR_CNT_W'(CLEAR_COUNT - 1);
		q_pop = fire && ((q_op.kind != lscw_pkg::OP_CLEAR) || clr_last);
	end

	always_comb begin
		res = '0;
		res_valid = 1'b0;
		res.end_of_run = 1'b1;
		case (q_op.kind)
			lscw_pkg::OP_TEXT: begin
				res_valid = changed;
				res.kind = lscw_pkg::KIND_CELL;
				res.cell_res = q_op.cell_num[3:0];
				res.byte0 = merged[0];
				res.byte1 = merged[1];
				res.byte2 = merged[2];
				res.byte3 = merged[3];
			end
			lscw_pkg::OP_CLEAR: begin
				res_valid = 1'b1;
				res.kind = lscw_pkg::KIND_CELL;
				res.cell_res = clr_cnt_q;
				res.byte0 = lscw_pkg::SPACE_CHAR;
				res.byte1 = lscw_pkg::SPACE_CHAR;
				res.byte2 = lscw_pkg::SPACE_CHAR;
				res.byte3 = lscw_pkg::SPACE_CHAR;
				res.end_of_run = clr_last;
			end
			lscw_pkg::OP_LIGHT: begin
				res_valid = light_chg;
				res.kind = lscw_pkg::KIND_LIGHT;
				res.light_index = q_op.light_id;
				res.light_state = q_op.light_req;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CELL_TOTAL; i++) begin
				shadow_q[i] <= '0;
			end
			light_q <= '0;
			clr_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				case (q_op.kind)
					lscw_pkg::OP_TEXT: begin
						if (changed) begin
							shadow_q[cell_idx] <= merged;
						end
					end
					lscw_pkg::OP_CLEAR: begin
						if (clr_cnt_q == '0) begin
							for (int i = 0; i < CELL_TOTAL; i++) begin
								shadow_q[i] <= {lscw_pkg::CELL_CHARS{lscw_pkg::SPACE_CHAR}};
							end
						end
						clr_cnt_q <= clr_last ? '0 : clr_cnt_q + 1'b1;
					end
					lscw_pkg::OP_LIGHT: begin
						if (light_chg) begin
							light_q[light_idx] <= q_op.light_req;
						end
					end
					default: begin
					end
				endcase
			end
			if (fire && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && (q_op.kind == lscw_pkg::OP_TEXT)) begin
			buf_q <= merged;
		end
		if (fire && res_valid) begin
			out_data_q <= res;
		end
	end

endmodule
`default_nettype wire
